// ===== hw/rtl/mhpq_pkg.sv =====
// Shared types and constants for the min-heap priority queue.
package mhpq_pkg;

    localparam int Capacity = 256;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_REMOVE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,       // latch command and value
        OP_APPEND,      // write value at the tail, position := tail
        OP_RD_LAST,     // read tail-1 entry
        OP_MOVE_LAST,   // write moved entry at position, count--
        OP_RD_PARENT,   // read parent of position
        OP_TAKE_PARENT, // keep parent entry and its slot
        OP_RD_LEFT,     // read left child
        OP_RD_RIGHT,    // keep left child, read right child
        OP_TAKE_CHILD,  // keep the smaller child and its slot
        OP_SWAP_A,      // write first half of a swap
        OP_SWAP_B,      // write second half, position := target
        OP_SCAN_NEXT,   // read scan index, advance
        OP_RD_ROOT      // read root for the minimum report
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       full;
        logic       pos_above_root; // position above zero
        logic       up_less;        // entry at position below its parent entry
        logic       has_left;
        logic       down_less;      // chosen child below entry at position
        logic       scan_hit;
        logic       scan_end;
        logic       pos_is_tail;    // found slot was the last one
    } dp_stat_t;

    function automatic logic slt(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

// ===== hw/rtl/mhpq_datapath.sv =====
// Datapath of the min-heap: entry store, position registers and compares.
module mhpq_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                cmd,
    input  logic [31:0]               value,
    input  mhpq_pkg::dp_cmd_t         ctl,
    output mhpq_pkg::dp_stat_t        stat,
    output logic [mhpq_pkg::CntW-1:0] count,
    output logic [31:0]               root_value,
    output logic [31:0]               result_value
);
    localparam int IW = mhpq_pkg::IdxW;
    localparam int CW = mhpq_pkg::CntW;

    logic [31:0]   mem [mhpq_pkg::Capacity];
    logic [31:0]   rdata_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] tgt_reg, tgt_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [31:0]   cur_reg, cur_next;   // entry at position
    logic [31:0]   a_reg, a_next;       // parent or chosen child
    logic [31:0]   val_reg, val_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [31:0]   res_reg, res_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [31:0]   wdata;
    logic          re;
    logic [CW:0]   left_w;
    logic [CW:0]   right_w;
    logic [CW-1:0] parent_w;
    logic          right_ok;
    logic          pick_right;
    logic [31:0]   child;

    assign left_w   = {pos_reg, 1'b1};
    assign right_w  = left_w + (CW+1)'(1);
    assign parent_w = (pos_reg - CW'(1)) >> 1;

    // After the right child read, rdata holds the right child and a_reg the left.
    assign right_ok   = right_w < (CW+1)'(count_reg);
    assign pick_right = right_ok && mhpq_pkg::slt(rdata_reg, a_reg);
    assign child      = pick_right ? rdata_reg : a_reg;

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        tgt_next   = tgt_reg;
        scan_next  = scan_reg;
        cur_next   = cur_reg;
        a_next     = a_reg;
        val_next   = val_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = cur_reg;
        re    = 1'b0;
        raddr = '0;
        case (ctl.op)
            mhpq_pkg::OP_START:
            begin
                cmd_next  = cmd;
                val_next  = value;
                res_next  = '0;
                scan_next = '0;
                pos_next  = '0;
                re        = 1'b1;
                raddr     = '0;
            end
            mhpq_pkg::OP_APPEND:
            begin
                we         = 1'b1;
                waddr      = IW'(count_reg);
                wdata      = val_reg;
                cur_next   = val_reg;
                pos_next   = count_reg;
                count_next = count_reg + CW'(1);
            end
            mhpq_pkg::OP_RD_LAST:
            begin
                re    = 1'b1;
                raddr = IW'(count_reg - CW'(1));
                if (cmd_reg == mhpq_pkg::CMD_EXTRACT)
                    res_next = rdata_reg;  // root read at start
            end
            mhpq_pkg::OP_MOVE_LAST:
            begin
                we         = 1'b1;
                waddr      = IW'(pos_reg);
                wdata      = rdata_reg;
                cur_next   = rdata_reg;
                count_next = count_reg - CW'(1);
            end
            mhpq_pkg::OP_RD_PARENT:
            begin
                re    = 1'b1;
                raddr = IW'(parent_w);
            end
            mhpq_pkg::OP_TAKE_PARENT:
            begin
                a_next   = rdata_reg;
                tgt_next = parent_w;
            end
            mhpq_pkg::OP_RD_LEFT:
            begin
                re    = 1'b1;
                raddr = IW'(left_w);
            end
            mhpq_pkg::OP_RD_RIGHT:
            begin
                a_next = rdata_reg;
                re     = 1'b1;
                raddr  = IW'(right_w);
            end
            mhpq_pkg::OP_TAKE_CHILD:
            begin
                a_next   = child;
                tgt_next = pick_right ? CW'(right_w) : CW'(left_w);
            end
            mhpq_pkg::OP_SWAP_A:
            begin
                // target entry moves to position
                we    = 1'b1;
                waddr = IW'(pos_reg);
                wdata = a_reg;
            end
            mhpq_pkg::OP_SWAP_B:
            begin
                we       = 1'b1;
                waddr    = IW'(tgt_reg);
                wdata    = cur_reg;
                pos_next = tgt_reg;
            end
            mhpq_pkg::OP_SCAN_NEXT:
            begin
                re        = 1'b1;
                raddr     = IW'(scan_reg);
                scan_next = scan_reg + CW'(1);
                pos_next  = scan_reg;
            end
            mhpq_pkg::OP_RD_ROOT:
            begin
                re    = 1'b1;
                raddr = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cmd_reg   <= '0;
            pos_reg   <= '0;
            tgt_reg   <= '0;
            scan_reg  <= '0;
            cur_reg   <= '0;
            a_reg     <= '0;
            val_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            cmd_reg   <= cmd_next;
            pos_reg   <= pos_next;
            tgt_reg   <= tgt_next;
            scan_reg  <= scan_next;
            cur_reg   <= cur_next;
            a_reg     <= a_next;
            val_reg   <= val_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        stat.cmd            = cmd_reg;
        stat.empty          = (count_reg == '0);
        stat.full           = (count_reg >= CW'(mhpq_pkg::Capacity));
        stat.pos_above_root = (pos_reg != '0);
        stat.up_less        = mhpq_pkg::slt(cur_reg, a_reg);
        stat.has_left       = left_w < (CW+1)'(count_reg);
        stat.down_less      = mhpq_pkg::slt(a_reg, cur_reg);
        stat.scan_hit       = (rdata_reg == val_reg);
        stat.scan_end       = (scan_reg >= count_reg);
        // The count has already dropped, so the old tail slot equals it.
        stat.pos_is_tail    = (pos_reg == count_reg);
    end

    assign count        = count_reg;
    assign root_value   = (count_reg == '0) ? '0 : rdata_reg;
    assign result_value = res_reg;
endmodule

// ===== hw/rtl/mhpq_ctrl.sv =====
// Controller state machine sequencing the heap operations.
module mhpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  mhpq_pkg::dp_stat_t stat,
    output mhpq_pkg::dp_cmd_t  ctl,
    output logic [1:0]         status
);
    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_APPEND, S_UP_RD, S_UP_WAIT, S_UP_CMP,
        S_LAST_RD, S_LAST_WAIT, S_MOVE, S_REPAIR, S_DN_RDA, S_DN_RDB,
        S_DN_WAIT, S_DN_CMP, S_SWAP_A, S_SWAP_B, S_SCAN, S_SCAN_WAIT,
        S_ROOT, S_ROOT_WAIT, S_DONE
    } state_t;

    state_t     state_reg;
    logic [1:0] status_reg;
    logic       up_mode_reg;  // current sift direction is upward
    logic       rep_reg;      // remove: decide direction first

    always_comb
    begin
        ctl.op = mhpq_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:      ctl.op = in_valid ? mhpq_pkg::OP_START : mhpq_pkg::OP_NONE;
            S_APPEND:    ctl.op = mhpq_pkg::OP_APPEND;
            S_UP_RD:     ctl.op = mhpq_pkg::OP_RD_PARENT;
            S_UP_WAIT:   ctl.op = mhpq_pkg::OP_TAKE_PARENT;
            S_LAST_RD:   ctl.op = mhpq_pkg::OP_RD_LAST;
            S_MOVE:      ctl.op = mhpq_pkg::OP_MOVE_LAST;
            S_DN_RDA:    ctl.op = mhpq_pkg::OP_RD_LEFT;
            S_DN_RDB:    ctl.op = mhpq_pkg::OP_RD_RIGHT;
            S_DN_WAIT:   ctl.op = mhpq_pkg::OP_TAKE_CHILD;
            S_SWAP_A:    ctl.op = mhpq_pkg::OP_SWAP_A;
            S_SWAP_B:    ctl.op = mhpq_pkg::OP_SWAP_B;
            S_SCAN:      ctl.op = mhpq_pkg::OP_SCAN_NEXT;
            S_ROOT:      ctl.op = mhpq_pkg::OP_RD_ROOT;
            default:     ctl.op = mhpq_pkg::OP_NONE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            status_reg  <= mhpq_pkg::ST_OK;
            up_mode_reg <= 1'b0;
            rep_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_DECODE;
                S_DECODE:
                begin
                    status_reg <= mhpq_pkg::ST_OK;
                    rep_reg    <= 1'b0;
                    case (stat.cmd)
                        mhpq_pkg::CMD_INSERT:
                            if (stat.full)
                            begin
                                status_reg <= mhpq_pkg::ST_FULL;
                                state_reg  <= S_ROOT;
                            end
                            else
                            begin
                                up_mode_reg <= 1'b1;
                                state_reg   <= S_APPEND;
                            end
                        mhpq_pkg::CMD_EXTRACT:
                            if (stat.empty)
                            begin
                                status_reg <= mhpq_pkg::ST_EMPTY;
                                state_reg  <= S_ROOT;
                            end
                            else
                            begin
                                up_mode_reg <= 1'b0;
                                state_reg   <= S_LAST_RD;
                            end
                        mhpq_pkg::CMD_REMOVE:
                            if (stat.empty)
                            begin
                                status_reg <= mhpq_pkg::ST_EMPTY;
                                state_reg  <= S_ROOT;
                            end
                            else
                            begin
                                status_reg <= mhpq_pkg::ST_NOTFOUND;
                                state_reg  <= S_SCAN;
                            end
                        default:
                            state_reg <= S_ROOT;
                    endcase
                end
                S_APPEND:  state_reg <= S_UP_RD;
                S_UP_RD:
                    state_reg <= stat.pos_above_root ? S_UP_WAIT : S_ROOT;
                S_UP_WAIT: state_reg <= S_UP_CMP;
                S_UP_CMP:
                    if (stat.up_less)
                        state_reg <= S_SWAP_A;
                    else if (rep_reg)
                    begin
                        rep_reg     <= 1'b0;
                        up_mode_reg <= 1'b0;
                        state_reg   <= S_DN_RDA;
                    end
                    else
                        state_reg <= S_ROOT;
                S_SCAN:      state_reg <= S_SCAN_WAIT;
                S_SCAN_WAIT:
                    if (stat.scan_hit)
                    begin
                        status_reg <= mhpq_pkg::ST_OK;
                        state_reg  <= S_LAST_RD;
                    end
                    else if (stat.scan_end)
                        state_reg <= S_ROOT;
                    else
                        state_reg <= S_SCAN;
                S_LAST_RD:   state_reg <= S_LAST_WAIT;
                S_LAST_WAIT: state_reg <= S_MOVE;
                S_MOVE:      state_reg <= S_REPAIR;
                S_REPAIR:
                    if (stat.pos_is_tail && stat.cmd == mhpq_pkg::CMD_REMOVE)
                        state_reg <= S_ROOT;
                    else if (stat.cmd == mhpq_pkg::CMD_REMOVE && stat.pos_above_root)
                    begin
                        rep_reg     <= 1'b1;
                        up_mode_reg <= 1'b1;
                        state_reg   <= S_UP_RD;
                    end
                    else
                    begin
                        up_mode_reg <= 1'b0;
                        state_reg   <= S_DN_RDA;
                    end
                S_DN_RDA:
                    state_reg <= stat.has_left ? S_DN_RDB : S_ROOT;
                S_DN_RDB:  state_reg <= S_DN_WAIT;
                S_DN_WAIT: state_reg <= S_DN_CMP;
                S_DN_CMP:
                    state_reg <= stat.down_less ? S_SWAP_A : S_ROOT;
                S_SWAP_A:  state_reg <= S_SWAP_B;
                S_SWAP_B:
                begin
                    rep_reg   <= 1'b0;
                    state_reg <= up_mode_reg ? S_UP_RD : S_DN_RDA;
                end
                S_ROOT:      state_reg <= S_ROOT_WAIT;
                S_ROOT_WAIT: state_reg <= S_DONE;
                S_DONE:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("ready while a result is pending");
    a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");
endmodule

// ===== hw/rtl/min_heap_priority_queue.sv =====
// Top level of the binary min-heap priority queue.
// Input stream s_axis: one request carries a command in tuser and a value in tdata.
// Output stream m_axis: one result for every request, in order, status in tuser.
// A request is taken only while the block is idle; each is worked through
// by the controller, one store access a cycle on a single-port entry store.
// The unused command and an insert into a full heap or an extract or remove on an
// empty one go straight to the minimum report. An insert appends and sifts up, an
// extract moves the tail entry to the root and sifts down, and a remove scans the
// entries one by one; when nothing is found it reports, else it moves the tail entry
// into the found slot and sifts, up first when the moved entry is below its parent.
// With 256 entries a remove may scan every entry before its repair.
// The result is taken at the first edge with m_axis_tready high, and the next
// request can be taken in the cycle after.
// After reset the heap is empty and no clearing pass is needed: only
// occupied slots are ever used.
// The result holds while m_axis_tready is low; no new request is
// taken until the result has gone.
module min_heap_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    input  logic [31:0] s_axis_tdata,  // value[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    output logic [79:0] m_axis_tdata   // result_value[31:0], min_value[63:32],
                                       // entry_count[72:64], zero fill
);
    mhpq_pkg::dp_cmd_t            ctl;
    mhpq_pkg::dp_stat_t           stat;
    logic [mhpq_pkg::CntW-1:0]    count;
    logic [31:0]                  root_value;
    logic [31:0]                  result_value;
    logic [1:0]                   status;

    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .ctl       (ctl),
        .status    (status)
    );

    mhpq_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (s_axis_tuser),
        .value        (s_axis_tdata),
        .ctl          (ctl),
        .stat         (stat),
        .count        (count),
        .root_value   (root_value),
        .result_value (result_value)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {7'd0, count, root_value, result_value};
endmodule

// ===== bench/min_heap_priority_queue_test.sv =====
// Self-checking testbench for the min-heap priority queue block.
module min_heap_priority_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [31:0]               result_value;
        logic [31:0]               min_value;
        logic [mhpq_pkg::CntW-1:0] entry_count;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [1:0]  m_axis_tuser;
    logic [79:0] m_axis_tdata;

    request_t pending_requests[$];
    reply_t   expected_replies[$];
    logic [31:0] heap_copy[mhpq_pkg::Capacity];
    int       heap_fill;
    int       failures;
    bit       calm_stretch;
    bit       stimulus_done;

    min_heap_priority_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit slt_value(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [31:0] t;
        t = heap_copy[a];
        heap_copy[a] = heap_copy[b];
        heap_copy[b] = t;
    endfunction

    function automatic void bubble_up(int pos);
        int up;
        while (pos > 0 && pos < heap_fill)
        begin
            up = (pos - 1) / 2;
            if (!slt_value(heap_copy[pos], heap_copy[up]))
                break;
            swap_entries(pos, up);
            pos = up;
        end
    endfunction

    function automatic void bubble_down(int pos);
        int left;
        int pick;
        while (pos < heap_fill)
        begin
            left = 2 * pos + 1;
            if (left >= heap_fill)
                break;
            pick = left;
            if (left + 1 < heap_fill && slt_value(heap_copy[left + 1], heap_copy[left]))
                pick = left + 1;
            if (!slt_value(heap_copy[pick], heap_copy[pos]))
                break;
            swap_entries(pos, pick);
            pos = pick;
        end
    endfunction

    // Applies one request to the shadow heap and returns the reply it should give.
    function automatic reply_t apply_request(request_t rq);
        reply_t rp;
        rp = '0;
        case (rq.cmd)
            mhpq_pkg::CMD_INSERT:
                if (heap_fill >= mhpq_pkg::Capacity)
                    rp.status = mhpq_pkg::ST_FULL;
                else
                begin
                    heap_copy[heap_fill] = rq.value;
                    heap_fill++;
                    bubble_up(heap_fill - 1);
                end
            mhpq_pkg::CMD_EXTRACT:
                if (heap_fill == 0)
                    rp.status = mhpq_pkg::ST_EMPTY;
                else
                begin
                    rp.result_value = heap_copy[0];
                    heap_fill--;
                    heap_copy[0] = heap_copy[heap_fill];
                    bubble_down(0);
                end
            mhpq_pkg::CMD_REMOVE:
                if (heap_fill == 0)
                    rp.status = mhpq_pkg::ST_EMPTY;
                else
                begin
                    rp.status = mhpq_pkg::ST_NOTFOUND;
                    for (int i = 0; i < heap_fill; i++)
                        if (heap_copy[i] == rq.value)
                        begin
                            heap_fill--;
                            heap_copy[i] = heap_copy[heap_fill];
                            if (i < heap_fill)
                            begin
                                if (i > 0 && slt_value(heap_copy[i], heap_copy[(i - 1) / 2]))
                                    bubble_up(i);
                                else
                                    bubble_down(i);
                            end
                            rp.status = mhpq_pkg::ST_OK;
                            break;
                        end
                end
            default: ;
        endcase
        rp.min_value   = (heap_fill > 0) ? heap_copy[0] : 32'd0;
        rp.entry_count = heap_fill[mhpq_pkg::CntW-1:0];
        return rp;
    endfunction

    // Keeps a sideline list of values that are likely held, so removes often hit.
    logic [31:0] held_values[$];

    task automatic queue_request(logic [1:0] cmd, logic [31:0] value);
        request_t rq;
        rq.cmd = cmd;
        rq.value = value;
        pending_requests.push_back(rq);
        if (cmd == mhpq_pkg::CMD_INSERT)
            held_values.push_back(value);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int target;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        heap_fill = 0;
        failures = 0;
        calm_stretch = 1'b0;
        stimulus_done = 1'b0;

        // Directed: empty cases, extremes, equal keys and the unused command.
        queue_request(mhpq_pkg::CMD_EXTRACT, 32'd0);
        queue_request(mhpq_pkg::CMD_REMOVE, 32'd5);
        queue_request(CMD_UNUSED, 32'hffff_ffff);
        queue_request(mhpq_pkg::CMD_INSERT, 32'h7fff_ffff);
        queue_request(mhpq_pkg::CMD_INSERT, 32'h8000_0000);
        queue_request(mhpq_pkg::CMD_INSERT, 32'd0);
        queue_request(mhpq_pkg::CMD_INSERT, 32'hffff_ffff);
        queue_request(mhpq_pkg::CMD_INSERT, 32'd7);
        queue_request(mhpq_pkg::CMD_INSERT, 32'd7);
        queue_request(mhpq_pkg::CMD_INSERT, 32'd7);
        queue_request(mhpq_pkg::CMD_REMOVE, 32'd12345);
        queue_request(mhpq_pkg::CMD_REMOVE, 32'd7);
        queue_request(mhpq_pkg::CMD_REMOVE, 32'h8000_0000);
        queue_request(CMD_UNUSED, 32'h5555_aaaa);
        queue_request(mhpq_pkg::CMD_EXTRACT, 32'haaaa_5555);
        queue_request(mhpq_pkg::CMD_EXTRACT, 32'd0);
        queue_request(mhpq_pkg::CMD_EXTRACT, 32'd0);
        queue_request(mhpq_pkg::CMD_EXTRACT, 32'd0);
        queue_request(mhpq_pkg::CMD_EXTRACT, 32'd0);
        queue_request(mhpq_pkg::CMD_EXTRACT, 32'd0);

        // One phase that fills past capacity and drains past empty, then mixed churn.
        while (pending_requests.size() < 800)
        begin
            if (pending_requests.size() < 100)
            begin
                target = mhpq_pkg::Capacity + $urandom_range(2, 6);
                for (int k = 0; k < target; k++)
                    queue_request(mhpq_pkg::CMD_INSERT, random_value());
                for (int k = 0; k < 20; k++)
                    queue_request(mhpq_pkg::CMD_REMOVE,
                        $urandom_range(0, 1) && held_values.size() > 0
                        ? held_values[$urandom_range(0, held_values.size() - 1)]
                        : random_value());
                for (int k = 0; k < target; k++)
                    queue_request(mhpq_pkg::CMD_EXTRACT, $urandom);
                held_values.delete();
            end
            else
            begin
                for (int k = 0; k < 40; k++)
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: queue_request(mhpq_pkg::CMD_INSERT, random_value());
                        4, 5:       queue_request(mhpq_pkg::CMD_EXTRACT, $urandom);
                        6, 7, 8:    queue_request(mhpq_pkg::CMD_REMOVE,
                                        held_values.size() > 0 && $urandom_range(0, 3) != 0
                                        ? held_values[$urandom_range(0, held_values.size() - 1)]
                                        : random_value());
                        default:    queue_request(CMD_UNUSED, $urandom);
                    endcase
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && !s_axis_tvalid);
        stimulus_done = 1'b1;
        wait (expected_replies.size() == 0);
        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("min_heap_priority_queue test passed");
        else
            $display("min_heap_priority_queue test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("min_heap_priority_queue test failed");
        $finish;
    end

    // A quiet stretch with no idling on either side, about a third of the way in.
    always @(posedge clk)
        calm_stretch <= (pending_requests.size() > 450 && pending_requests.size() < 600);

    // Request driver.
    always @(posedge clk)
    begin
        request_t rq;
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_requests.size() > 0 && (calm_stretch || $urandom_range(0, 99) >= 32))
                begin
                    rq = pending_requests.pop_front();
                    s_axis_tuser  <= rq.cmd;
                    s_axis_tdata  <= rq.value;
                    s_axis_tvalid <= 1'b1;
                    expected_replies.push_back(apply_request(rq));
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= calm_stretch || $urandom_range(0, 99) >= 32;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status       = m_axis_tuser;
            got.result_value = m_axis_tdata[31:0];
            got.min_value    = m_axis_tdata[63:32];
            got.entry_count  = m_axis_tdata[72:64];
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result %h %h", $realtime, m_axis_tuser, m_axis_tdata);
                failures++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.status != want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, got.status);
                    failures++;
                end
                if (got.result_value != want.result_value)
                begin
                    $display("%0t: result_value expected %0d actual %0d", $realtime,
                             $signed(want.result_value), $signed(got.result_value));
                    failures++;
                end
                if (got.min_value != want.min_value)
                begin
                    $display("%0t: min_value expected %0d actual %0d", $realtime,
                             $signed(want.min_value), $signed(got.min_value));
                    failures++;
                end
                if (got.entry_count != want.entry_count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $realtime, want.entry_count, got.entry_count);
                    failures++;
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_datapath.sv
hw/rtl/mhpq_ctrl.sv
hw/rtl/min_heap_priority_queue.sv
bench/min_heap_priority_queue_test.sv
